FILE: rtl/core/mrr_pkg.sv
// Shared constants, types and verdict codes for the Miller-Rabin round block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package mrr_pkg;

    localparam int NUM_BITS = 63;
    localparam int CNT_W    = $clog2(NUM_BITS);
    localparam int T_W      = $clog2(NUM_BITS);
    localparam int VERDICT_W = 2;

    typedef logic [NUM_BITS-1:0]  word_t;
    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_COMPOSITE = 2'd0;
    localparam verdict_t VERDICT_PRIME     = 2'd1;
    localparam verdict_t VERDICT_PROBABLE  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/mrr_moddiv.sv
// Bit-serial restoring divider giving dividend mod divisor, one quotient bit per cycle.
// Depends on mrr_pkg.
`default_nettype none

module mrr_moddiv
    import mrr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t dividend,
    input  wire word_t divisor,
    output logic       done,
    output word_t      rem
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            dvd_reg, dvd_next;
    word_t            dsr_reg, dsr_next;
    logic [NUM_BITS:0] trial;

    assign trial = {rem_reg, dvd_reg[NUM_BITS-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_BITS - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so one subtract per bit suffices
            if (trial >= {1'b0, dsr_reg})
                rem_next = word_t'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[NUM_BITS-1:0];
            dvd_next = {dvd_reg[NUM_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not reduced");

endmodule

`default_nettype wire

FILE: rtl/core/mrr_modmul.sv
// Shift-and-add modular multiplier: one multiplier bit per cycle on a pair of modular adders.
// Depends on mrr_pkg.
`default_nettype none

module mrr_modmul
    import mrr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t op_a,
    input  wire word_t op_b,
    input  wire word_t modulus,
    output logic       done,
    output word_t      result
);

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    word_t acc_reg, acc_next;
    word_t add_reg, add_next;
    word_t mlt_reg, mlt_next;
    word_t n_reg, n_next;
    logic [NUM_BITS:0] acc_sum, add_sum;

    // operands are below the modulus, so sums need one conditional subtract
    assign acc_sum = {1'b0, acc_reg} + {1'b0, add_reg};
    assign add_sum = {1'b0, add_reg} + {1'b0, add_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        add_next  = add_reg;
        mlt_next  = mlt_reg;
        n_next    = n_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            add_next  = op_a;
            mlt_next  = op_b;
            n_next    = modulus;
        end
        else if (busy_reg)
        begin
            if (mlt_reg[0])
            begin
                if (acc_sum >= {1'b0, n_reg})
                    acc_next = word_t'(acc_sum - {1'b0, n_reg});
                else
                    acc_next = acc_sum[NUM_BITS-1:0];
            end
            if (add_sum >= {1'b0, n_reg})
                add_next = word_t'(add_sum - {1'b0, n_reg});
            else
                add_next = add_sum[NUM_BITS-1:0];
            mlt_next = mlt_reg >> 1;
            // stop once no multiplier bits remain
            if (mlt_next == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        add_reg <= add_next;
        mlt_reg <= mlt_next;
        n_reg   <= n_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("multiplier done without a run");

endmodule

`default_nettype wire

FILE: rtl/core/miller_rabin_round.sv
// One Miller-Rabin round. n<2 and even n go straight to FIN with a fixed verdict.
// Odd n: base divide, split of n-1 into u*2^t, square-and-multiply passes over the bits
// of u (POW, PMUL, PSQ), then up to t squarings (SQR, SSQ) before FIN.
// No new word is taken until the verdict leaves FIN; output stalls hold the sequencer in FIN.
// Reset (rst_n, async low) returns the sequencer to idle and empties the output register.
// Depends on mrr_pkg, mrr_moddiv, mrr_modmul.
`default_nettype none

module miller_rabin_round
    import mrr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire word_t    candidate,
    input  wire word_t    random_word,
    output logic          out_valid,
    input  wire logic     out_stall,
    output verdict_t      verdict
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_SPLIT = 4'd2;
    localparam logic [3:0] ST_POW   = 4'd3;
    localparam logic [3:0] ST_PMUL  = 4'd4;
    localparam logic [3:0] ST_PSQ   = 4'd5;
    localparam logic [3:0] ST_SQR   = 4'd6;
    localparam logic [3:0] ST_SSQ   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0]     state_reg, state_next;
    word_t          n_reg, n_next;
    word_t          u_reg, u_next;
    word_t          x_reg, x_next;
    word_t          b_reg, b_next;
    logic [T_W-1:0] t_reg, t_next;
    verdict_t       verd_reg, verd_next;
    verdict_t       verdict_reg, verdict_next;
    logic           out_valid_reg, out_valid_next;

    logic  div_start, div_done;
    word_t div_rem;
    logic  mul_start, mul_done;
    word_t mul_a, mul_b, mul_res;
    word_t nm1;

    assign nm1 = n_reg - word_t'(1);

    mrr_moddiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (random_word),
        .divisor  (candidate - word_t'(1)),
        .done     (div_done),
        .rem      (div_rem)
    );

    mrr_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (n_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        u_next         = u_reg;
        x_next         = x_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        verd_next      = verd_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        mul_start      = 1'b0;
        mul_a          = x_reg;
        mul_b          = b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = candidate;
                    if (candidate < word_t'(2))
                    begin
                        verd_next  = VERDICT_COMPOSITE;
                        state_next = ST_FIN;
                    end
                    else if (!candidate[0])
                    begin
                        verd_next  = (candidate == word_t'(2)) ? VERDICT_PRIME
                                                               : VERDICT_COMPOSITE;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    b_next     = div_rem + word_t'(1);
                    u_next     = nm1;
                    t_next     = '0;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                    t_next = t_reg + T_W'(1);
                end
                else
                begin
                    x_next     = word_t'(1);
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (u_reg == '0)
                    state_next = ST_SQR;
                else if (u_reg[0])
                begin
                    mul_start  = 1'b1;
                    state_next = ST_PMUL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = b_reg;
                    state_next = ST_PSQ;
                end
            end
            ST_PMUL:
            begin
                if (mul_done)
                begin
                    x_next = mul_res;
                    // base squaring is skipped after the last exponent bit
                    if (u_reg[NUM_BITS-1:1] == '0)
                    begin
                        u_next     = '0;
                        state_next = ST_SQR;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = b_reg;
                        state_next = ST_PSQ;
                    end
                end
            end
            ST_PSQ:
            begin
                if (mul_done)
                begin
                    b_next     = mul_res;
                    u_next     = u_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_SQR:
            begin
                if (t_reg == '0)
                begin
                    verd_next  = (x_reg == word_t'(1)) ? VERDICT_PROBABLE
                                                       : VERDICT_COMPOSITE;
                    state_next = ST_FIN;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_b      = x_reg;
                    state_next = ST_SSQ;
                end
            end
            ST_SSQ:
            begin
                if (mul_done)
                begin
                    // nontrivial square root of one found
                    if (mul_res == word_t'(1) && x_reg != word_t'(1) && x_reg != nm1)
                    begin
                        verd_next  = VERDICT_COMPOSITE;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        x_next     = mul_res;
                        t_next     = t_reg - T_W'(1);
                        state_next = ST_SQR;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = verd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        u_reg       <= u_next;
        x_reg       <= x_next;
        b_reg       <= b_next;
        t_reg       <= t_next;
        verd_reg    <= verd_next;
        verdict_reg <= verdict_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQR || state_reg == ST_SSQ) |-> (x_reg < n_reg))
        else $error("running value not reduced mod n");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg == VERDICT_COMPOSITE ||
                           verdict_reg == VERDICT_PRIME ||
                           verdict_reg == VERDICT_PROBABLE))
        else $error("reserved verdict code on output");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for miller_rabin_round: queued stimulus, clocked driver and monitor.
// Expected verdicts come from a local bit-accurate round model; needs mrr_pkg and the RTL.
`default_nettype none

module tb_top
    import mrr_pkg::*;
();

    localparam int  N_RANDOM    = 77;
    localparam int  HOLDOFF_AT  = 30;       // results seen before the long output hold-off
    localparam int  HOLDOFF_LEN = 40000;    // a few worst-case rounds, so the input backs up
    localparam int  DRAIN_WAIT  = 100;
    localparam longint CYCLE_LIMIT = 10_000_000;

    typedef bit [63:0] u64_t;

    typedef struct {
        word_t cand;
        word_t word;
        bit    drain_first;   // hold this word back until every verdict is in
    } round_req_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    word_t    candidate = '0;
    word_t    random_word = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    verdict_t verdict;

    round_req_t  round_reqs[$];
    verdict_t    expected_verdicts[$];

    int          n_accepted = 0;
    int          n_results = 0;
    int          error_count = 0;
    int          n_composite = 0;
    int          n_two = 0;
    int          n_probable = 0;
    longint      cycle_count = 0;

    int          burst_left = 0;
    int          gap_left = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_timer = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;
    int          phase_cnt = 0;

    miller_rabin_round DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .candidate   (candidate),
        .random_word (random_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- round model ----------------

    function automatic u64_t addmod(u64_t x, u64_t y, u64_t n);
        u64_t s;
        s = x + y;
        return (s >= n) ? s - n : s;
    endfunction

    // shift-and-add product, one multiplier bit per step
    function automatic u64_t mulmod(u64_t a, u64_t b, u64_t n);
        u64_t acc;
        u64_t addend;
        acc = 0;
        addend = a;
        for (int i = 0; i < NUM_BITS; i++)
        begin
            if (b[i])
                acc = addmod(acc, addend, n);
            addend = addmod(addend, addend, n);
        end
        return acc;
    endfunction

    function automatic u64_t powmod(u64_t a, u64_t e, u64_t n);
        u64_t res;
        u64_t sq;
        res = 1;
        sq = a;
        for (int i = 0; i < NUM_BITS; i++)
        begin
            if (e[i])
                res = mulmod(res, sq, n);
            sq = mulmod(sq, sq, n);
        end
        return res;
    endfunction

    function automatic bit base_is_witness(u64_t a, u64_t n);
        u64_t u;
        u64_t x;
        u64_t nx;
        int   t;
        u = n - 1;
        t = 0;
        while (u[0] == 1'b0 && t < NUM_BITS)
        begin
            u = u >> 1;
            t++;
        end
        x = powmod(a, u, n);
        for (int i = 0; i < t; i++)
        begin
            nx = mulmod(x, x, n);
            // nontrivial square root of one
            if (nx == 1 && x != 1 && x != n - 1)
                return 1'b1;
            x = nx;
        end
        return x != 1;
    endfunction

    function automatic verdict_t round_verdict(word_t cand, word_t word);
        u64_t n;
        u64_t r;
        u64_t a;
        n = u64_t'(cand);
        r = u64_t'(word);
        if (n < 2)
            return VERDICT_COMPOSITE;
        if (n[0] == 1'b0)
            return (n == 2) ? VERDICT_PRIME : VERDICT_COMPOSITE;
        a = (r % (n - 1)) + 1;
        return base_is_witness(a, n) ? VERDICT_COMPOSITE : VERDICT_PROBABLE;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic u64_t rand_bits(int w);
        u64_t v;
        v = {$urandom, $urandom};
        if (w < 64)
            v = v & ((u64_t'(1) << w) - 1);
        return v;
    endfunction

    function automatic bit passes_two_bases(u64_t n);
        return round_verdict(word_t'(n), word_t'(1)) == VERDICT_PROBABLE &&
               round_verdict(word_t'(n), word_t'(2)) == VERDICT_PROBABLE;
    endfunction

    // most candidates small so the serial multiplier stays quick
    function automatic int pick_width();
        return ($urandom_range(0, 3) == 0) ? NUM_BITS : $urandom_range(2, 40);
    endfunction

    function automatic word_t pick_odd_candidate();
        u64_t lim;
        u64_t v;
        u64_t k;
        int   w;
        int   t;
        lim = (u64_t'(1) << NUM_BITS) - 1;
        w = pick_width();
        if ($urandom_range(0, 5) == 0)
        begin
            // k * 2^t + 1: long squaring chain
            t = $urandom_range(1, w - 1);
            k = rand_bits(w - t) | 1;
            for (int s = 0; s < 100; s++)
            begin
                v = (k << t) + 1;
                if (v > lim || passes_two_bases(v))
                    break;
                k = k + 2;
            end
            if (v > lim)
                v = (u64_t'(1) << t) + 1;
            return word_t'(v);
        end
        v = rand_bits(w) | (u64_t'(1) << (w - 1)) | 1;
        if ($urandom_range(0, 2) != 0)
        begin
            // walk up to a likely prime so the round runs to the end
            for (int s = 0; s < 300; s++)
            begin
                if (passes_two_bases(v))
                    break;
                v = v + 2;
                if (v > lim)
                    v = 3;
            end
        end
        return word_t'(v);
    endfunction

    function automatic word_t pick_word(word_t cand);
        u64_t n;
        n = u64_t'(cand);
        if (n < 2)
            return word_t'(rand_bits(NUM_BITS));
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return word_t'(n - 2);     // base n-1
            2:       return word_t'(n - 1);     // base one
            3:       return '1;
            default: return word_t'(rand_bits(NUM_BITS));
        endcase
    endfunction

    task automatic add_round(input u64_t cand, input u64_t word, input bit drain);
        round_req_t req;
        req.cand = word_t'(cand);
        req.word = word_t'(word);
        req.drain_first = drain;
        round_reqs = {round_reqs, req};
    endtask

    // ---------------- driver ----------------

    always @(posedge clk)
    begin : drive
        int acc_now;
        acc_now = n_accepted;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_verdicts = {expected_verdicts, round_verdict(candidate, random_word)};
                void'(round_reqs.pop_front());
                acc_now = n_accepted + 1;
                n_accepted <= acc_now;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            if (in_valid && in_stall)
            begin
                // word held until taken
            end
            else if (round_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (round_reqs[0].drain_first && acc_now != n_results)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                candidate <= round_reqs[0].cand;
                random_word <= round_reqs[0].word;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : watch
        verdict_t want;
        bit       stall_next;
        stall_next = 1'b0;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results <= n_results + 1;
                case (verdict)
                    VERDICT_PRIME:    n_two++;
                    VERDICT_PROBABLE: n_probable++;
                    default:          n_composite++;
                endcase
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: verdict with nothing expected: actual %0d", $time, verdict);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict !== want)
                    begin
                        error_count++;
                        $display("%0t: verdict mismatch: expected %0d actual %0d",
                                 $time, want, verdict);
                    end
                end
            end

            if (mode_timer == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_timer = $urandom_range(16, 200);
            end
            else
                mode_timer = mode_timer - 1;

            if (!holdoff_done && n_results >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end

            phase_cnt = phase_cnt + 1;
            if (holdoff_left > 0)
            begin
                holdoff_left = holdoff_left - 1;
                stall_next = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: stall_next = (phase_cnt % 3 != 0);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("[miller_rabin_round] ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        word_t cand;
        u64_t  lim;
        lim = (u64_t'(1) << NUM_BITS) - 1;

        // directed: below two, even cases, tiny odd, extremes, known hard cases
        add_round(0, 0, 1'b0);
        add_round(1, lim, 1'b0);
        add_round(2, 0, 1'b0);
        add_round(2, lim, 1'b0);
        add_round(4, 3, 1'b0);
        add_round(lim - 1, lim, 1'b0);
        add_round(3, 0, 1'b0);
        add_round(3, 1, 1'b0);
        add_round(5, 3, 1'b0);
        add_round(9, 7, 1'b0);
        add_round(lim, lim, 1'b0);
        add_round(lim, 0, 1'b0);
        add_round(64'd9223372036854775783, rand_bits(NUM_BITS), 1'b0);
        add_round(64'd9223372036854775783, 64'd9223372036854775781, 1'b0);
        add_round(64'd2305843009213693951, rand_bits(NUM_BITS), 1'b0);
        add_round(561, 0, 1'b0);
        add_round(561, 1, 1'b0);
        add_round(2047, 1, 1'b0);
        add_round(64'd3215031751, 1, 1'b0);
        add_round(64'd3215031751, 10, 1'b0);
        add_round(64'd3221225473, rand_bits(NUM_BITS), 1'b0);
        add_round(64'd469762049, 64'd469762048 * 3, 1'b0);
        add_round((u64_t'(1) << 62) + 1, rand_bits(NUM_BITS), 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // noise: any parity, any size
                if ($urandom_range(0, 1) == 0)
                    cand = word_t'(rand_bits(NUM_BITS));
                else
                    cand = word_t'(rand_bits($urandom_range(1, 12)));
            end
            else
                cand = pick_odd_candidate();
            add_round(u64_t'(cand), u64_t'(pick_word(cand)), i == 0 || i == N_RANDOM * 2 / 3);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (round_reqs.size() != 0 || n_accepted != n_results)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_verdicts.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
        end
        $display("Ran %0d rounds: %0d composite, %0d n=2, %0d probable prime.",
                 n_results, n_composite, n_two, n_probable);
        $display("Included a long output hold-off and sender pauses until fully drained.");
        if (error_count == 0)
            $display("[miller_rabin_round] OK");
        else
            $display("[miller_rabin_round] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
